FILE: design/tdr_pkg.sv
// Types and constants shared by the TFTP download receiver.
`timescale 1ns / 1ps
package tdr_pkg;

    localparam int unsigned MIN_PACKET = 4;

    typedef enum logic [1:0] {
        CMD_PACKET  = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_WAITERR = 2'd2,
        CMD_START   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        SEND_NONE  = 2'd0,
        SEND_ACK   = 2'd1,
        SEND_ERROR = 2'd2
    } send_kind_t;

    localparam logic [2:0] ERR_UNDEF   = 3'd0;
    localparam logic [2:0] ERR_ACCESS  = 3'd2;
    localparam logic [2:0] ERR_ILLEGAL = 3'd4;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam logic [1:0] STATUS_IDLE = 2'd0;
    localparam logic [1:0] STATUS_RUN  = 2'd1;
    localparam logic [1:0] STATUS_OK   = 2'd2;
    localparam logic [1:0] STATUS_FAIL = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RUN  = 4'b0010,
        PH_OK   = 4'b0100,
        PH_FAIL = 4'b1000
    } phase_t;

    localparam logic [1:0] REG_MAX_MESSAGE   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_START = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_STEP  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] packet_length;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic        decode_ok;
        logic        write_ok;
    } event_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] ack_block;
        logic [2:0]  error_code;
        logic        store_block;
        logic [1:0]  status;
    } result_t;

    function automatic logic [1:0] status_of(phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_RUN:  code = STATUS_RUN;
            PH_OK:   code = STATUS_OK;
            PH_FAIL: code = STATUS_FAIL;
            default: code = STATUS_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: design/tdr_stream_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface tdr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/tftp_download_receiver_top.sv
// TFTP download receiver: event decision logic, transfer state and APB registers.
//
//   Channel | Direction | Payload
//   evt     | in        | command, packet_length, packet_opcode, packet_block,
//           |           | decode_ok, write_ok
//   res     | out       | send_kind, ack_block, error_code, store_block, status
//   apb     | in/out    | max_message, timeout_start, timeout_step, timeout_limit
//
// One request is accepted per cycle unless a stalled result keeps the input register full.
// A request is held in the input register; the combinational decision logic, which also
// updates the transfer state, writes its result into the result register. A stalled
// result holds there while the input register still takes one more request. Reset
// returns the valid flags, configuration and transfer state to defaults, phase idle.
`timescale 1ns / 1ps
module tftp_download_receiver_top
    import tdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tdr_stream_if.sink   evt,
    tdr_stream_if.source res
);

    logic [15:0] max_message_reg;
    logic [19:0] timeout_start_reg;
    logic [19:0] timeout_step_reg;
    logic [19:0] timeout_limit_reg;

    logic        in_valid_reg;
    event_t      in_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    logic [15:0] expected_reg;
    logic [15:0] expected_next;
    logic [19:0] timeout_reg;
    logic [19:0] timeout_next;
    phase_t      phase_reg;
    phase_t      phase_next;

    logic        out_free;
    logic        load;
    logic        cfg_write;
    logic [20:0] timeout_sum;
    logic [19:0] timeout_sat;
    logic        len_bad;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_message_reg   <= 16'd516;
            timeout_start_reg <= 20'd500000;
            timeout_step_reg  <= 20'd100000;
            timeout_limit_reg <= 20'd900000;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MAX_MESSAGE:   max_message_reg   <= pwdata[15:0];
                REG_TIMEOUT_START: timeout_start_reg <= pwdata[19:0];
                REG_TIMEOUT_STEP:  timeout_step_reg  <= pwdata[19:0];
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= pwdata[19:0];
                default:           max_message_reg   <= max_message_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_MESSAGE:   prdata = {16'd0, max_message_reg};
            REG_TIMEOUT_START: prdata = {12'd0, timeout_start_reg};
            REG_TIMEOUT_STEP:  prdata = {12'd0, timeout_step_reg};
            REG_TIMEOUT_LIMIT: prdata = {12'd0, timeout_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign out_free  = !out_valid_reg || res.ready;
    assign load      = in_valid_reg && out_free;
    assign evt.ready = !in_valid_reg || out_free;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            in_reg <= evt.data;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 16'd1;
            timeout_reg  <= 20'd500000;
            phase_reg    <= PH_IDLE;
        end
        else if (load)
        begin
            expected_reg <= expected_next;
            timeout_reg  <= timeout_next;
            phase_reg    <= phase_next;
        end
    end

    assign timeout_sum = {1'b0, timeout_reg} + {1'b0, timeout_step_reg};
    assign timeout_sat = timeout_sum[20] ? 20'hFFFFF : timeout_sum[19:0];
    assign len_bad     = (in_reg.packet_length < 16'(MIN_PACKET))
                         || (in_reg.packet_length > max_message_reg);

    always_comb
    begin
        expected_next         = expected_reg;
        timeout_next          = timeout_reg;
        phase_next            = phase_reg;
        out_next.send_kind    = SEND_NONE;
        out_next.ack_block    = 16'd0;
        out_next.error_code   = ERR_UNDEF;
        out_next.store_block  = 1'b0;

        if (in_reg.command == CMD_START)
        begin
            expected_next = 16'd1;
            timeout_next  = timeout_start_reg;
            phase_next    = PH_RUN;
        end
        else if (phase_reg == PH_RUN)
        begin
            case (in_reg.command)
                CMD_PACKET:
                begin
                    timeout_next = timeout_start_reg;
                    if (len_bad)
                    begin
                        out_next.send_kind  = SEND_ERROR;
                        out_next.error_code = ERR_ILLEGAL;
                    end
                    else if (!in_reg.decode_ok)
                    begin
                        out_next.send_kind = SEND_ERROR;
                        phase_next         = PH_FAIL;
                    end
                    else if (in_reg.packet_opcode == OP_DATA)
                    begin
                        if (in_reg.packet_block == expected_reg)
                        begin
                            if (in_reg.packet_length == 16'(MIN_PACKET))
                            begin
                                out_next.send_kind = SEND_ACK;
                                out_next.ack_block = in_reg.packet_block;
                                phase_next         = PH_OK;
                            end
                            else if (!in_reg.write_ok)
                            begin
                                out_next.send_kind  = SEND_ERROR;
                                out_next.error_code = ERR_ACCESS;
                                phase_next          = PH_FAIL;
                            end
                            else
                            begin
                                out_next.store_block = 1'b1;
                                out_next.send_kind   = SEND_ACK;
                                out_next.ack_block   = in_reg.packet_block;
                                expected_next        = expected_reg + 16'd1;
                                if (in_reg.packet_length != max_message_reg)
                                begin
                                    phase_next = PH_OK;
                                end
                            end
                        end
                    end
                    else if (in_reg.packet_opcode == OP_ERROR)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        out_next.send_kind  = SEND_ERROR;
                        out_next.error_code = ERR_ILLEGAL;
                        phase_next          = PH_FAIL;
                    end
                end
                CMD_TICK:
                begin
                    if (expected_reg != 16'd1)
                    begin
                        out_next.send_kind = SEND_ACK;
                        out_next.ack_block = expected_reg - 16'd1;
                    end
                    timeout_next = timeout_sat;
                    if (timeout_sat >= timeout_limit_reg)
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                default:
                begin
                    out_next.send_kind = SEND_ERROR;
                    phase_next         = PH_FAIL;
                end
            endcase
        end

        out_next.status = status_of(phase_next);
    end

    a_store_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.store_block |-> res.data.send_kind == SEND_ACK)
        else $error("store without ACK");

    a_status_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> res.data.status == status_of(phase_reg))
        else $error("result status differs from phase");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_reg.command == CMD_START |=> expected_reg == 16'd1
            && timeout_reg == timeout_start_reg && phase_reg == PH_RUN)
        else $error("start did not restart transfer");

    a_no_error_code_without_error: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.send_kind != SEND_ERROR |-> res.data.error_code == ERR_UNDEF)
        else $error("error code set without error packet");

endmodule

FILE: tb/tdr_response_checker.sv
// Response checker for the TFTP download receiver: predicts every response and compares it.
`timescale 1ns / 1ps
module tdr_response_checker
    import tdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        evt_valid,
    input  logic        evt_ready,
    input  event_t      evt_data,
    input  logic        res_valid,
    input  logic        res_ready,
    input  result_t     res_data,
    output int          pending,
    output int          failures
);

    logic [15:0] max_len;
    logic [19:0] tmo_start;
    logic [19:0] tmo_step;
    logic [19:0] tmo_limit;

    logic [15:0] next_block;
    logic [19:0] tmo_value;
    logic [1:0]  xfer_status;

    result_t     awaited_responses[$];
    result_t     oldest;
    int          mismatch_count;

    function automatic result_t decide_response(input event_t e);
        result_t     r;
        logic [20:0] grown;
        r = '0;
        if (e.command == CMD_START)
        begin
            next_block = 16'd1;
            tmo_value = tmo_start;
            xfer_status = STATUS_RUN;
        end
        else if (xfer_status == STATUS_RUN)
        begin
            case (e.command)
                CMD_PACKET:
                begin
                    tmo_value = tmo_start;
                    if (e.packet_length < MIN_PACKET || e.packet_length > max_len)
                    begin
                        r.send_kind = SEND_ERROR;
                        r.error_code = ERR_ILLEGAL;
                    end
                    else if (!e.decode_ok)
                    begin
                        r.send_kind = SEND_ERROR;
                        r.error_code = ERR_UNDEF;
                        xfer_status = STATUS_FAIL;
                    end
                    else if (e.packet_opcode == OP_DATA)
                    begin
                        if (e.packet_block == next_block)
                        begin
                            if (e.packet_length == MIN_PACKET)
                            begin
                                r.send_kind = SEND_ACK;
                                r.ack_block = e.packet_block;
                                xfer_status = STATUS_OK;
                            end
                            else if (!e.write_ok)
                            begin
                                r.send_kind = SEND_ERROR;
                                r.error_code = ERR_ACCESS;
                                xfer_status = STATUS_FAIL;
                            end
                            else
                            begin
                                r.store_block = 1'b1;
                                r.send_kind = SEND_ACK;
                                r.ack_block = e.packet_block;
                                next_block = next_block + 16'd1;
                                if (e.packet_length != max_len)
                                begin
                                    xfer_status = STATUS_OK;
                                end
                            end
                        end
                    end
                    else if (e.packet_opcode == OP_ERROR)
                    begin
                        xfer_status = STATUS_FAIL;
                    end
                    else
                    begin
                        r.send_kind = SEND_ERROR;
                        r.error_code = ERR_ILLEGAL;
                        xfer_status = STATUS_FAIL;
                    end
                end
                CMD_TICK:
                begin
                    // A tick re-acknowledges the last stored block, if there is one.
                    if (next_block != 16'd1)
                    begin
                        r.send_kind = SEND_ACK;
                        r.ack_block = next_block - 16'd1;
                    end
                    grown = {1'b0, tmo_value} + {1'b0, tmo_step};
                    tmo_value = (grown > 21'hFFFFF) ? 20'hFFFFF : grown[19:0];
                    if (tmo_value >= tmo_limit)
                    begin
                        xfer_status = STATUS_FAIL;
                    end
                end
                default:
                begin
                    r.send_kind = SEND_ERROR;
                    r.error_code = ERR_UNDEF;
                    xfer_status = STATUS_FAIL;
                end
            endcase
        end
        r.status = xfer_status;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected kind=%0d ack=%0d err=%0d store=%0b status=%0d",
                     $time, what, want.send_kind, want.ack_block, want.error_code,
                     want.store_block, want.status,
                     ", got kind=%0d ack=%0d err=%0d store=%0b status=%0d",
                     got.send_kind, got.ack_block, got.error_code, got.store_block,
                     got.status);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len = 16'd516;
            tmo_start = 20'd500000;
            tmo_step = 20'd100000;
            tmo_limit = 20'd900000;
            next_block = 16'd1;
            tmo_value = 20'd500000;
            xfer_status = STATUS_IDLE;
            awaited_responses.delete();
            mismatch_count = 0;
            pending <= 0;
            failures <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MAX_MESSAGE:   max_len = pwdata[15:0];
                    REG_TIMEOUT_START: tmo_start = pwdata[19:0];
                    REG_TIMEOUT_STEP:  tmo_step = pwdata[19:0];
                    REG_TIMEOUT_LIMIT: tmo_limit = pwdata[19:0];
                    default: ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    report_mismatch("response with no request outstanding", '0, res_data);
                end
                else
                begin
                    oldest = awaited_responses.pop_front();
                    if (oldest !== res_data)
                    begin
                        report_mismatch("response mismatch", oldest, res_data);
                    end
                end
            end
            if (evt_valid && evt_ready)
            begin
                awaited_responses.push_back(decide_response(evt_data));
            end
            pending <= awaited_responses.size();
            failures <= mismatch_count;
        end
    end

endmodule

FILE: tb/tftp_download_receiver_top_test.sv
// Stimulus, clocking and verdict for the TFTP download receiver testbench.
`timescale 1ns / 1ps
module tftp_download_receiver_top_test;
    import tdr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          failures;
    int          cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_trigger;
    int          items_sent;
    logic [15:0] full_length;

    tdr_stream_if #(.payload_t(event_t))  evt_if ();
    tdr_stream_if #(.payload_t(result_t)) res_if ();

    tftp_download_receiver_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .evt     (evt_if),
        .res     (res_if)
    );

    tdr_response_checker response_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .evt_valid (evt_if.valid),
        .evt_ready (evt_if.ready),
        .evt_data  (evt_if.data),
        .res_valid (res_if.valid),
        .res_ready (res_if.ready),
        .res_data  (res_if.data),
        .pending   (pending),
        .failures  (failures)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The response side stalls at random and, when asked, holds off for a long stretch.
    initial
    begin : response_sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_trigger)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic event_t make_event(input command_t cmd, input logic [15:0] len,
                                          input logic [15:0] op, input logic [15:0] blk,
                                          input logic dec, input logic wr);
        event_t e;
        e.command = cmd;
        e.packet_length = len;
        e.packet_opcode = op;
        e.packet_block = blk;
        e.decode_ok = dec;
        e.write_ok = wr;
        return e;
    endfunction

    function automatic event_t random_event();
        event_t e;
        e.command = 2'($urandom_range(3));
        e.packet_length = 16'($urandom);
        e.packet_opcode = 16'($urandom);
        e.packet_block = 16'($urandom);
        e.decode_ok = 1'($urandom_range(1));
        e.write_ok = 1'($urandom_range(1));
        return e;
    endfunction

    task automatic send_event(input event_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            @(posedge clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.data <= e;
        do @(posedge clk); while (!evt_if.ready);
        items_sent++;
    endtask

    task automatic drain();
        evt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] max_len, input logic [19:0] t_start,
                             input logic [19:0] t_step, input logic [19:0] t_limit);
        drain();
        apb_write(REG_MAX_MESSAGE, {16'd0, max_len});
        apb_write(REG_TIMEOUT_START, {12'd0, t_start});
        apb_write(REG_TIMEOUT_STEP, {12'd0, t_step});
        apb_write(REG_TIMEOUT_LIMIT, {12'd0, t_limit});
        full_length = max_len;
    endtask

    // Mostly in-order full blocks ending in a short one, mixed with ticks,
    // retransmitted blocks, bad lengths and arbitrary requests.
    task automatic run_transfer(input int blocks);
        event_t      e;
        logic [15:0] blk;
        int          sent_blocks;
        int          pick;
        blk = 16'd1;
        sent_blocks = 0;
        e = random_event();
        e.command = CMD_START;
        send_event(e);
        while (sent_blocks < blocks)
        begin
            e = random_event();
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                sent_blocks++;
                e = make_event(CMD_PACKET, full_length, OP_DATA, blk, 1'b1,
                               1'($urandom_range(39) != 0));
                if (sent_blocks == blocks && full_length > MIN_PACKET)
                begin
                    e.packet_length = 16'($urandom_range(MIN_PACKET, int'(full_length) - 1));
                end
                blk = blk + 16'd1;
            end
            else if (pick < 82)
            begin
                e.command = CMD_TICK;
            end
            else if (pick < 88)
            begin
                e = make_event(CMD_PACKET, full_length, OP_DATA,
                               blk - 16'($urandom_range(1, 3)), 1'b1, 1'b1);
            end
            else if (pick < 93)
            begin
                e.command = CMD_PACKET;
                if (full_length == 16'hFFFF || $urandom_range(1) == 0)
                begin
                    e.packet_length = 16'($urandom_range(MIN_PACKET - 1));
                end
                else
                begin
                    e.packet_length = 16'($urandom_range(int'(full_length) + 1, 65535));
                end
            end
            send_event(e);
        end
    endtask

    initial
    begin
        int seg_base;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        evt_if.valid <= 1'b0;
        evt_if.data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_trigger = 0;
        items_sent = 0;
        full_length = 16'd516;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Events before any transfer change nothing; then a transfer meets bad lengths, a wrong block and a good block.
        send_event(make_event(CMD_PACKET, 16'd516, OP_DATA, 16'd1, 1'b1, 1'b1));
        send_event(make_event(CMD_TICK, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send_event(make_event(CMD_PACKET, 16'd0, 16'd0, 16'd1, 1'b1, 1'b1));
        send_event(make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd1, 1'b1, 1'b1));
        send_event(make_event(CMD_PACKET, 16'd516, OP_DATA, 16'hFFFF, 1'b1, 1'b1));
        send_event(make_event(CMD_PACKET, 16'd516, OP_DATA, 16'd1, 1'b1, 1'b1));
        // Four ticks bring the timeout exactly to the limit.
        repeat (4) send_event(make_event(CMD_TICK, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_START, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_TICK, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_PACKET, 16'd516, OP_DATA, 16'd1, 1'b1, 1'b0));
        send_event(make_event(CMD_START, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_PACKET, 16'd4, OP_DATA, 16'd1, 1'b1, 1'b1));
        send_event(make_event(CMD_START, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_PACKET, 16'd516, OP_DATA, 16'd1, 1'b0, 1'b1));
        send_event(make_event(CMD_START, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_PACKET, 16'd4, OP_ERROR, 16'd1, 1'b1, 1'b1));
        send_event(make_event(CMD_START, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_PACKET, 16'd20, 16'hFFFF, 16'd1, 1'b1, 1'b1));
        send_event(make_event(CMD_START, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_event(make_event(CMD_WAITERR, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));

        // Long response hold-off while requests keep coming.
        hold_trigger++;
        run_transfer(12);
        drain();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0: configure(16'd516, 20'd500000, 20'd100000, 20'd900000);
                1: configure(16'd4, 20'd0, 20'd0, 20'd0);
                2: configure(16'd65535, 20'd999999, 20'd999999, 20'd999999);
                3: configure(16'd600, 20'd10, 20'd5, 20'd40);
                4: configure(16'd1024, 20'd0, 20'd999999, 20'd999999);
                default: configure(16'd516, 20'd100, 20'd0, 20'd999999);
            endcase
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            seg_base = items_sent;
            while (items_sent - seg_base < 140)
            begin
                run_transfer($urandom_range(1, 10));
            end
        end

        drain();
        if (failures == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
